/* hdl/drp_pkg.sv */
// Shared types, constants and helpers of the delta Rice sample encoder.
package drp_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 10;
    localparam int ZZ_W     = 11;
    localparam int K_W      = 4;
    localparam int Q_W      = 8;
    localparam int POS_W    = 9;
    localparam int LEFT_W   = 6;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 3;

    localparam logic [K_W-1:0]  K_MIN         = 4'd3;
    localparam logic [K_W-1:0]  K_MAX         = 4'd10;
    localparam logic [K_W-1:0]  K_RESET       = 4'd3;
    localparam logic [ZZ_W-1:0] SENTINEL_CODE = 11'd1024;
    localparam logic [ZZ_W-1:0] PADDING_CODE  = 11'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_RUN
    } drp_state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
    } drp_cmd_t;

    typedef struct packed {
        logic out_hold;
        logic item_done;
    } drp_status_t;

    function automatic logic [K_W-1:0] eff_k(input logic [K_W-1:0] rice);
        logic [K_W-1:0] k;
        k = rice;
        if (rice < K_MIN)
        begin
            k = K_MIN;
        end
        else if (rice > K_MAX)
        begin
            k = K_MAX;
        end
        return k;
    endfunction

endpackage

/* hdl/drp_ctrl.sv */
// Controller state machine of the delta Rice sample encoder.
module drp_ctrl
    import drp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  drp_status_t status,
    output drp_cmd_t    cmd
);

    drp_state_t state_reg;
    drp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (!status.out_hold && status.item_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_RUN:
            begin
                cmd.step = !status.out_hold;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/drp_datapath.sv */
// Datapath: quantiser, delta and zigzag, Rice bit packer and output register.
module drp_datapath
    import drp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [K_W-1:0]             cfg_wr_data,
    input  logic                       func,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  drp_cmd_t                   cmd,
    output drp_status_t                status,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [BYTE_W-1:0]          code_byte,
    output logic                       last_of_run,
    output logic                       stream_end
);

    logic [K_W-1:0]    rice_reg;
    logic [LEVEL_W-1:0] prev_reg;
    logic [BYTE_W-1:0] acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [ZZ_W-1:0]   x_reg;
    logic [Q_W-1:0]    q_reg;
    logic [POS_W-1:0]  len_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              fin_reg;
    logic              seg2_reg;
    logic [LEFT_W-1:0] left_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] code_byte_reg;
    logic              last_reg;
    logic              end_reg;

    logic [K_W-1:0]    k;
    logic [LEVEL_W-1:0] level;
    logic [ZZ_W-1:0]   diff;
    logic [ZZ_W-1:0]   zz;
    logic [ZZ_W-1:0]   q_full;
    logic [Q_W-1:0]    q_cur;
    logic [POS_W-1:0]  len_cur;
    logic [ZZ_W-1:0]   pad_q_full;
    logic [Q_W-1:0]    pad_q;
    logic [POS_W-1:0]  pad_len;
    logic [POS_W-1:0]  total;
    logic [3:0]        avail;
    logic [POS_W-1:0]  rem;
    logic [3:0]        fill;
    logic [3:0]        sum;
    logic              byte_full;
    logic              cw_done;
    logic              item_done;
    logic [15:0]       x_ext;
    logic [POS_W-1:0]  q9;
    logic [BYTE_W-1:0] take;
    logic [BYTE_W-1:0] lane_bit;
    logic [BYTE_W-1:0] acc_new;

    assign k          = eff_k(rice_reg);
    assign level      = sample[SAMPLE_W-1:SAMPLE_W-LEVEL_W];
    assign diff       = {level[LEVEL_W-1], level} - {prev_reg[LEVEL_W-1], prev_reg};
    assign zz         = {diff[ZZ_W-2:0], 1'b0} ^ {ZZ_W{diff[ZZ_W-1]}};

    assign q_full     = x_reg >> k;
    assign q_cur      = q_full[Q_W-1:0];
    assign len_cur    = POS_W'(q_cur) + POS_W'(1) + POS_W'(k);
    assign pad_q_full = PADDING_CODE >> k;
    assign pad_q      = pad_q_full[Q_W-1:0];
    assign pad_len    = POS_W'(pad_q) + POS_W'(1) + POS_W'(k);
    assign total      = POS_W'(cnt_reg) + len_cur + (fin_reg ? pad_len : '0);

    assign avail      = 4'd8 - 4'(cnt_reg);
    assign rem        = len_reg - pos_reg;
    assign fill       = (rem < POS_W'(avail)) ? rem[3:0] : avail;
    assign sum        = 4'(cnt_reg) + fill;
    assign byte_full  = sum[3];
    assign cw_done    = (pos_reg + POS_W'(fill)) == len_reg;
    assign item_done  = cw_done && !seg2_reg;

    assign x_ext      = {5'b0, x_reg};
    assign q9         = POS_W'(q_reg);

    for (genvar j = 0; j < BYTE_W; j++)
    begin : g_lane
        logic [POS_W-1:0] p;
        logic [POS_W-1:0] r;
        assign p           = pos_reg + POS_W'(j) - POS_W'(cnt_reg);
        assign r           = p - q9 - POS_W'(1);
        assign take[j]     = (CNT_W'(j) >= cnt_reg) && (4'(j) < sum);
        assign lane_bit[j] = take[j] & ((p < q9) ? 1'b0 : (p == q9) ? 1'b1 : x_ext[r[3:0]]);
    end

    assign acc_new = acc_reg | lane_bit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rice_reg <= K_RESET;
        end
        else if (cfg_wr_en)
        begin
            rice_reg <= cfg_wr_data;
        end
    end

    // accumulator, count and previous level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                prev_reg <= func ? '0 : level;
            end
            if (cmd.step)
            begin
                if (byte_full || (item_done && fin_reg))
                begin
                    acc_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_new;
                    cnt_reg <= sum[CNT_W-1:0];
                end
            end
        end
    end

    // codeword sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg  <= 1'b0;
            seg2_reg <= 1'b0;
            pos_reg  <= '0;
            left_reg <= '0;
        end
        else if (cmd.load)
        begin
            fin_reg  <= func;
            seg2_reg <= func;
            pos_reg  <= '0;
        end
        else if (cmd.prep)
        begin
            left_reg <= total[POS_W-1:CNT_W];
        end
        else if (cmd.step)
        begin
            if (cw_done && seg2_reg)
            begin
                seg2_reg <= 1'b0;
                pos_reg  <= '0;
            end
            else
            begin
                pos_reg <= pos_reg + POS_W'(fill);
            end
            if (byte_full)
            begin
                left_reg <= left_reg - LEFT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= func ? SENTINEL_CODE : zz;
        end
        else if (cmd.prep)
        begin
            q_reg   <= q_cur;
            len_reg <= len_cur;
        end
        else if (cmd.step && cw_done && seg2_reg)
        begin
            x_reg   <= PADDING_CODE;
            q_reg   <= pad_q;
            len_reg <= pad_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step && byte_full)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && byte_full)
        begin
            code_byte_reg <= acc_new;
            last_reg      <= (left_reg == LEFT_W'(1));
            end_reg       <= (left_reg == LEFT_W'(1)) && fin_reg;
        end
    end

    assign status.out_hold  = out_valid_reg && !out_ready;
    assign status.item_done = item_done;

    assign out_valid   = out_valid_reg;
    assign code_byte   = code_byte_reg;
    assign last_of_run = last_reg;
    assign stream_end  = end_reg;

endmodule

/* hdl/delta_rice_sample_encoder.sv */
// Top level of the delta Rice sample encoder: controller and datapath.
// An item is accepted in ST_IDLE and its codewords are sized in ST_PREP; in ST_RUN the packer then makes
// one step per cycle while the output is not held, a step emitting at most one registered output byte.
// Reset (rst_n low, asynchronous) clears the state, the bit accumulator and sets k to 3.
module delta_rice_sample_encoder
    import drp_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [K_W-1:0]             cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       func,
    input  logic signed [SAMPLE_W-1:0] sample,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [BYTE_W-1:0]          code_byte,
    output logic                       last_of_run,
    output logic                       stream_end
);

    drp_cmd_t    cmd;
    drp_status_t status;

    drp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    drp_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .func        (func),
        .sample      (sample),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_byte   (code_byte),
        .last_of_run (last_of_run),
        .stream_end  (stream_end)
    );

endmodule

/* hdl/drp_checker.sv */
// Port-level checker of the delta Rice sample encoder, bound to the top level.
module drp_checker
    import drp_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [BYTE_W-1:0] code_byte,
    input logic              last_of_run,
    input logic              stream_end
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item still in work");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> last_of_run)
        else $error("stream end flagged on a byte that is not last of its item");

    a_idle_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_ready |-> last_of_run)
        else $error("idle while bytes of an item are still due");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(code_byte)
            && $stable(last_of_run) && $stable(stream_end))
        else $error("stalled output item changed");

endmodule

bind delta_rice_sample_encoder drp_checker u_drp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .code_byte   (code_byte),
    .last_of_run (last_of_run),
    .stream_end  (stream_end)
);

/* sim/tb.sv */
// Self-checking testbench of the delta Rice sample encoder: random items, stalls and byte checks.
module tb;
    import drp_pkg::*;

    localparam logic FN_SAMPLE = 1'b0;
    localparam logic FN_FINISH = 1'b1;
    localparam int   DRAIN_CYCLES = 40;
    localparam int   SQUEEZE_CYCLES = 300;
    localparam int   RANDOM_ITEMS = 200;

    typedef struct {
        logic                       func;
        logic signed [SAMPLE_W-1:0] sample;
    } sample_item_t;

    typedef struct {
        logic [BYTE_W-1:0] code_byte;
        logic              last_of_run;
        logic              stream_end;
    } code_byte_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [K_W-1:0]             cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       func = FN_SAMPLE;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [BYTE_W-1:0]          code_byte;
    logic                       last_of_run;
    logic                       stream_end;

    sample_item_t pending_items[$];
    code_byte_t   expected_bytes[$];

    logic signed [LEVEL_W-1:0] model_level = '0;
    logic [BYTE_W-1:0]         model_bits = '0;
    int                        model_count = 0;
    logic [K_W-1:0]            model_rice = K_RESET;

    int   fail_count = 0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_left = 0;
    logic calm = 1'b0;
    logic squeeze_req = 1'b0;
    logic squeeze_seen = 1'b0;

    delta_rice_sample_encoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .code_byte   (code_byte),
        .last_of_run (last_of_run),
        .stream_end  (stream_end)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
        begin
            return 0;
        end
        else if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    task automatic push_bit(input logic b);
        code_byte_t cb;
        model_bits[model_count] = b;
        model_count++;
        if (model_count == 8)
        begin
            cb.code_byte   = model_bits;
            cb.last_of_run = 1'b0;
            cb.stream_end  = 1'b0;
            expected_bytes.push_back(cb);
            model_bits  = '0;
            model_count = 0;
        end
    endtask

    task automatic put_codeword(input int x, input int k);
        repeat (x >> k) push_bit(1'b0);
        push_bit(1'b1);
        for (int i = 0; i < k; i++)
        begin
            push_bit(((x >> i) & 1) == 1);
        end
    endtask

    task automatic encode_item(input logic f, input logic signed [SAMPLE_W-1:0] s);
        int                        k;
        int                        n0;
        int                        diff;
        int                        zz;
        logic signed [SAMPLE_W-1:0] shifted;
        logic signed [LEVEL_W-1:0]  level;
        k = int'(model_rice);
        if (model_rice < K_MIN)
        begin
            k = int'(K_MIN);
        end
        else if (model_rice > K_MAX)
        begin
            k = int'(K_MAX);
        end
        n0 = expected_bytes.size();
        if (f == FN_SAMPLE)
        begin
            shifted = s >>> 6;
            level   = shifted[LEVEL_W-1:0];
            diff    = int'(level) - int'(model_level);
            zz      = (diff >= 0) ? 2 * diff : -2 * diff - 1;
            model_level = level;
            put_codeword(zz, k);
            if (expected_bytes.size() > n0)
            begin
                expected_bytes[$].last_of_run = 1'b1;
            end
        end
        else
        begin
            put_codeword(int'(SENTINEL_CODE), k);
            put_codeword(int'(PADDING_CODE), k);
            if (expected_bytes.size() > n0)
            begin
                expected_bytes[$].last_of_run = 1'b1;
                expected_bytes[$].stream_end  = 1'b1;
            end
            model_level = '0;
            model_bits  = '0;
            model_count = 0;
        end
    endtask

    // Driver: hold the item until taken, then idle or offer the next one.
    always @(posedge clk or negedge rst_n)
    begin
        sample_item_t nxt;
        logic         taken;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func     <= FN_SAMPLE;
            sample   <= '0;
            send_gap <= 0;
        end
        else
        begin
            taken = in_valid && in_ready;
            if (taken)
            begin
                encode_item(func, sample);
            end
            if (in_valid && !taken)
            begin
                in_valid <= 1'b1;
            end
            else if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_items.size() > 0)
            begin
                nxt = pending_items.pop_front();
                in_valid <= 1'b1;
                func     <= nxt.func;
                sample   <= nxt.sample;
                send_gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, started once on request.
    always @(posedge clk)
    begin
        if (squeeze_req && !squeeze_seen)
        begin
            squeeze_seen <= 1'b1;
            hold_left    <= SQUEEZE_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each taken byte with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        code_byte_t want;
        logic       ready_next;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            ready_next = 1'b1;
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("unexpected byte %0h", code_byte);
                    fail_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (code_byte !== want.code_byte)
                    begin
                        $error("code_byte expected %0h actual %0h", want.code_byte, code_byte);
                        fail_count++;
                    end
                    if (last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run expected %0b actual %0b",
                               want.last_of_run, last_of_run);
                        fail_count++;
                    end
                    if (stream_end !== want.stream_end)
                    begin
                        $error("stream_end expected %0b actual %0b",
                               want.stream_end, stream_end);
                        fail_count++;
                    end
                end
                recv_gap <= pick_gap();
            end
            else if (recv_gap > 0)
            begin
                recv_gap   <= recv_gap - 1;
                ready_next = 1'b0;
            end
            if (recv_gap > 0 && !(out_valid && out_ready))
            begin
                ready_next = 1'b0;
            end
            out_ready <= ready_next && (hold_left == 0);
        end
    end

    task automatic queue_item(input logic f, input logic signed [SAMPLE_W-1:0] s);
        sample_item_t it;
        it.func   = f;
        it.sample = s;
        pending_items.push_back(it);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] gen_sample(input int prev);
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            v = prev + int'($urandom_range(0, 1024)) - 512;
            if (v > 32767)
            begin
                v = 32767;
            end
            if (v < -32768)
            begin
                v = -32768;
            end
        end
        else if (r < 8)
        begin
            v = $urandom;
        end
        else
        begin
            v = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    task automatic write_rice(input logic [K_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        model_rice = v;
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        while ((pending_items.size() != 0 || in_valid || expected_bytes.size() != 0)
               && n < 100000)
        begin
            @(posedge clk);
            n++;
        end
        if (expected_bytes.size() != 0)
        begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            fail_count++;
            expected_bytes.delete();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int             issued;
        int             phase;
        int             streams;
        int             len;
        int             last_s;
        logic [K_W-1:0] k_val;
        logic signed [SAMPLE_W-1:0] s;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset value of the Rice parameter.
        queue_item(FN_SAMPLE, 16'sd0);
        queue_item(FN_SAMPLE, 16'sd0);
        queue_item(FN_SAMPLE, 16'sd32767);
        queue_item(FN_SAMPLE, -16'sd32768);
        queue_item(FN_SAMPLE, 16'sd32767);
        queue_item(FN_SAMPLE, -16'sd1);
        queue_item(FN_SAMPLE, 16'sd63);
        queue_item(FN_SAMPLE, 16'sd64);
        queue_item(FN_SAMPLE, -16'sd64);
        queue_item(FN_SAMPLE, -16'sd65);
        queue_item(FN_SAMPLE, 16'sh5555);
        queue_item(FN_SAMPLE, 16'shAAAA);
        queue_item(FN_FINISH, 16'sd0);
        queue_item(FN_FINISH, -16'sd1);
        queue_item(FN_SAMPLE, 16'sd0);
        queue_item(FN_FINISH, 16'sd0);
        queue_item(FN_SAMPLE, -16'sd32768);
        queue_item(FN_SAMPLE, 16'sd32767);
        queue_item(FN_FINISH, 16'sd0);
        wait_drained();

        issued = 0;
        phase  = 0;
        last_s = 0;
        while (issued < RANDOM_ITEMS)
        begin
            case (phase)
                0: k_val = 4'd10;
                1: k_val = 4'd0;
                2: k_val = 4'd15;
                3: k_val = 4'd3;
                default: k_val = K_W'($urandom_range(0, 15));
            endcase
            write_rice(k_val);
            calm <= (phase == 1) || ($urandom_range(0, 3) == 0);
            if (phase == 1)
            begin
                squeeze_req <= 1'b1;
            end
            streams = $urandom_range(2, 4);
            repeat (streams)
            begin
                len = $urandom_range(0, 10);
                repeat (len)
                begin
                    s = gen_sample(last_s);
                    last_s = int'(s);
                    queue_item(FN_SAMPLE, s);
                end
                s = SAMPLE_W'($urandom);
                queue_item(FN_FINISH, s);
                last_s = 0;
                issued += len + 1;
            end
            wait_drained();
            phase++;
        end

        if (fail_count == 0)
        begin
            $display("delta_rice_sample_encoder test passed");
        end
        else
        begin
            $display("delta_rice_sample_encoder test failed");
        end
        $finish;
    end

    initial
    begin
        #10000000;
        $display("delta_rice_sample_encoder test failed");
        $finish;
    end

endmodule
